### rtl/low_energy_envelope_core_assert.svh
// assertion macros shared by the envelope checker
`ifndef LOW_ENERGY_ENVELOPE_CORE_ASSERT_SVH
`define LOW_ENERGY_ENVELOPE_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define LEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lee_pkg.sv
// shared types and constants of the low-energy envelope core
`timescale 1ns / 1ps
`default_nettype none

package lee_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int WLEN_W     = 8;
    localparam int KEEP_W     = 7;
    localparam int SCALE_W    = 16;
    localparam int SUM_W      = SAMPLE_W + KEEP_W;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int FRAC_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WLEN_W-1:0]   WLEN_RESET  = WLEN_W'(100);
    localparam logic [KEEP_W-1:0]   KEEP_RESET  = KEEP_W'(20);
    localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(2276);
    localparam logic [SAMPLE_W-1:0] ENV_MAX     = {SAMPLE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SORT,
        S_SUM,
        S_MUL,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic hist_push;
        logic hist_rotate;
        logic sort_clear;
        logic sort_insert;
        logic sort_drain;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/lee_cell.sv
// one cell of the history and insertion-sort chain
`timescale 1ns / 1ps
`default_nettype none

module lee_cell import lee_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [SAMPLE_W-1:0] i_key,
    input  wire logic [SAMPLE_W-1:0] i_hist_lo,
    input  wire logic [SAMPLE_W-1:0] i_hist_hi,
    input  wire logic [SAMPLE_W-1:0] i_sort_lo,
    input  wire logic                i_occ_lo,
    input  wire logic                i_gt_lo,
    input  wire logic [SAMPLE_W-1:0] i_sort_hi,
    output logic      [SAMPLE_W-1:0] o_hist,
    output logic      [SAMPLE_W-1:0] o_sort,
    output logic                     o_occ,
    output logic                     o_gt
);

    logic [SAMPLE_W-1:0] r_hist;
    logic [SAMPLE_W-1:0] r_sort;
    logic                r_occ;
    logic                w_take;

    // key belongs at or before this slot
    assign o_gt   = !r_occ || (r_sort > i_key);
    assign w_take = i_ctl.sort_insert && o_gt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.hist_push) begin
            r_hist <= i_hist_lo;
        end else if (i_ctl.hist_rotate) begin
            r_hist <= i_hist_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sort <= i_gt_lo ? i_sort_lo : i_key;
        end else if (i_ctl.sort_drain) begin
            r_sort <= i_sort_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.sort_clear) begin
            r_occ <= 1'b0;
        end else if (w_take) begin
            r_occ <= i_gt_lo ? i_occ_lo : 1'b1;
        end
    end

    assign o_hist = r_hist;
    assign o_sort = r_sort;
    assign o_occ  = r_occ;

endmodule

`default_nettype wire

### rtl/lee_scaler.sv
// two-stage multiply, round and saturate of the window sum
`timescale 1ns / 1ps
`default_nettype none

module lee_scaler import lee_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SUM_W-1:0]    i_sum,
    input  wire logic [SCALE_W-1:0]  i_scale,
    output logic                     o_done,
    output logic      [SAMPLE_W-1:0] o_envelope
);

    localparam int ROUND_W = PROD_W + 1;
    localparam int SHIFT_W = ROUND_W - FRAC_W;

    logic [PROD_W-1:0]   r_prod;
    logic                r_prod_valid;
    logic [SAMPLE_W-1:0] r_env;
    logic                r_done;
    logic [ROUND_W-1:0]  w_round;
    logic [SHIFT_W-1:0]  w_shift;
    logic [SAMPLE_W-1:0] n_env;

    always_comb begin
        w_round = {1'b0, r_prod} + ROUND_W'(1 << (FRAC_W - 1));
        w_shift = w_round[ROUND_W-1:FRAC_W];
        if (|w_shift[SHIFT_W-1:SAMPLE_W]) begin
            n_env = ENV_MAX;
        end else begin
            n_env = w_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(i_scale);
        end
        if (r_prod_valid) begin
            r_env <= n_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_prod_valid <= i_start;
            r_done       <= r_prod_valid;
        end
    end

    assign o_done     = r_done;
    assign o_envelope = r_env;

endmodule

`default_nettype wire

### rtl/low_energy_envelope_core.sv
// top level of the low-energy envelope (noise-floor) tracker
// One energy sample per beat enters a chain of WINDOW cells that holds the recent history
// and a sorted list. For an item that yields a result, let k be the smaller of keep_count
// and the number of samples in the window: the history is rotated once through cell 0
// while each sample of the window is inserted into the sorted list, then the k smallest
// values are drained one per cycle into the accumulator, then a two-stage multiply, round
// and saturate follows. During warm-up an item yields no result. The next sample is taken
// while a finished result still waits on the output. Configuration is to be written only
// while the core is idle; the user is bound to this, the core itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module low_energy_envelope_core import lee_pkg::*; #(
    parameter int WINDOW = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [SAMPLE_W-1:0]   o_envelope,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int STEP_W = $clog2(WINDOW);
    localparam int LEN_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int KC_W   = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    t_state              r_state;
    t_state              n_state;
    logic [WLEN_W-1:0]   r_window_length;
    logic [KEEP_W-1:0]   r_keep_count;
    logic [SCALE_W-1:0]  r_scale;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_k;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_sum;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_envelope;

    t_cell_ctl           w_ctl;
    logic                w_scale_start;
    logic                w_load_out;
    logic                w_scale_done;
    logic [SAMPLE_W-1:0] w_scaled;
    logic                w_last_step;

    logic [LEN_W-1:0]    w_len_ext;
    logic [LEN_W-1:0]    w_len_clamp;
    logic [CNT_W-1:0]    w_half;
    logic [CNT_W-1:0]    w_span;
    logic [CNT_W-1:0]    w_cnt;
    logic [CNT_W-1:0]    w_k;

    logic [SAMPLE_W-1:0] w_hist [WINDOW];
    logic [SAMPLE_W-1:0] w_sort [WINDOW];
    logic                w_occ  [WINDOW];
    logic                w_gt   [WINDOW];

    // window geometry from the current configuration
    always_comb begin
        w_len_ext = LEN_W'(r_window_length);
        if (w_len_ext > LEN_W'(WINDOW)) begin
            w_len_clamp = LEN_W'(WINDOW);
        end else if (w_len_ext < LEN_W'(2)) begin
            w_len_clamp = LEN_W'(2);
        end else begin
            w_len_clamp = w_len_ext;
        end
        w_half = CNT_W'(w_len_clamp >> 1);
        w_span = CNT_W'(w_len_clamp & ~LEN_W'(1));
        w_cnt  = (r_fill < w_span) ? r_fill : w_span;
        w_k    = (KC_W'(r_keep_count) < KC_W'(w_cnt)) ? CNT_W'(r_keep_count) : w_cnt;
    end

    assign w_last_step = (r_step == STEP_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_ctl         = '0;
        w_scale_start = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_ctl.hist_push = 1'b1;
                    n_state         = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_fill < w_half) begin
                    n_state = S_IDLE;
                end else begin
                    w_ctl.sort_clear = 1'b1;
                    n_state          = S_SORT;
                end
            end
            S_SORT: begin
                w_ctl.hist_rotate = 1'b1;
                w_ctl.sort_insert = (CNT_W'(r_step) < r_cnt);
                if (w_last_step) begin
                    n_state = (r_k == '0) ? S_MUL : S_SUM;
                end
            end
            S_SUM: begin
                w_ctl.sort_drain = 1'b1;
                if (CNT_W'(r_step) + CNT_W'(1) == r_k) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_scale_start = 1'b1;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                if (w_scale_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WLEN_RESET;
            r_keep_count    <= KEEP_RESET;
            r_scale         <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[WLEN_W-1:0];
                CFG_KEEP_COUNT:    r_keep_count    <= i_cfg_data[KEEP_W-1:0];
                CFG_SCALE:         r_scale         <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
            r_k    <= '0;
            r_step <= '0;
            r_sum  <= '0;
        end else begin
            if (w_ctl.hist_push && (r_fill != CNT_W'(WINDOW))) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (r_state == S_SETUP) begin
                r_cnt  <= w_cnt;
                r_k    <= w_k;
                r_step <= '0;
                r_sum  <= '0;
            end else if (w_ctl.hist_rotate) begin
                r_step <= w_last_step ? '0 : r_step + STEP_W'(1);
            end else if (w_ctl.sort_drain) begin
                r_step <= r_step + STEP_W'(1);
                r_sum  <= r_sum + SUM_W'(w_sort[0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_envelope <= w_scaled;
        end
    end

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic [SAMPLE_W-1:0] w_hist_lo;
        logic [SAMPLE_W-1:0] w_hist_hi;
        logic [SAMPLE_W-1:0] w_sort_lo;
        logic [SAMPLE_W-1:0] w_sort_hi;
        logic                w_occ_lo;
        logic                w_gt_lo;

        if (g == 0) begin : g_head
            assign w_hist_lo = i_sample;
            assign w_sort_lo = '0;
            assign w_occ_lo  = 1'b0;
            assign w_gt_lo   = 1'b0;
        end else begin : g_link_lo
            assign w_hist_lo = w_hist[g-1];
            assign w_sort_lo = w_sort[g-1];
            assign w_occ_lo  = w_occ[g-1];
            assign w_gt_lo   = w_gt[g-1];
        end

        if (g == WINDOW - 1) begin : g_tail
            assign w_hist_hi = w_hist[0];
            assign w_sort_hi = '0;
        end else begin : g_link_hi
            assign w_hist_hi = w_hist[g+1];
            assign w_sort_hi = w_sort[g+1];
        end

        lee_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_key     (w_hist[0]),
            .i_hist_lo (w_hist_lo),
            .i_hist_hi (w_hist_hi),
            .i_sort_lo (w_sort_lo),
            .i_occ_lo  (w_occ_lo),
            .i_gt_lo   (w_gt_lo),
            .i_sort_hi (w_sort_hi),
            .o_hist    (w_hist[g]),
            .o_sort    (w_sort[g]),
            .o_occ     (w_occ[g]),
            .o_gt      (w_gt[g])
        );
    end

    lee_scaler u_scaler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_scale_start),
        .i_sum      (r_sum),
        .i_scale    (r_scale),
        .o_done     (w_scale_done),
        .o_envelope (w_scaled)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_envelope  = r_envelope;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

### rtl/lee_checker.sv
// port-level checks of the envelope core and their binding
`timescale 1ns / 1ps
`default_nettype none

`include "low_energy_envelope_core_assert.svh"

module lee_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_envelope
);

    `LEE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_envelope), "result beat changed while stalled")
    `LEE_ASSERT_NOW(a_result_after_busy, $rose(i_out_valid), !$past(i_in_ready), "result beat appeared without a busy cycle")
    `LEE_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "input taken twice in a row")
    `LEE_ASSERT_NEXT(a_no_early_result, i_in_valid && i_in_ready, !$rose(i_out_valid), "result beat one cycle after an input beat")

endmodule

bind low_energy_envelope_core lee_checker u_lee_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_envelope  (o_envelope)
);

`default_nettype wire
